[src/inversive_congruential_prng_defines.svh]
// ----------------------------------------------------------------------------
// Inversive congruential PRNG - assertion macros
// Concurrent check helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef INVERSIVE_CONGRUENTIAL_PRNG_DEFINES_SVH
`define INVERSIVE_CONGRUENTIAL_PRNG_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ICG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icg: same-cycle check failed");

// next-cycle implication
`define ICG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icg: next-cycle check failed");

`else

`define ICG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ICG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/icg_pkg.sv]
// ----------------------------------------------------------------------------
// icg_pkg
// Shared types and constants of the inversive congruential PRNG.
// ----------------------------------------------------------------------------
package icg_pkg;

  localparam int ICG_WIDTH   = 32;
  localparam int ICG_SEED_W  = 32;
  localparam int ICG_VALUE_W = 32;

  localparam logic [63:0] MULT_RESET = 64'd1;
  localparam logic [63:0] INCR_RESET = 64'd1;
  localparam logic [63:0] MOD_RESET  = 64'd2147483647;

  typedef enum logic {
    OP_NEXT = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_MULT = 2'd0,
    REG_INCR = 2'd1,
    REG_MOD  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_SEED,
    ST_RED_A,
    ST_RED_C,
    ST_RED_X,
    ST_EUC_CHK,
    ST_EUC_DIV,
    ST_EUC_UPD,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } eng_state_t;

  // controls for the bit-serial divider
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // controls for the Horner multiply-mod unit
  typedef struct packed {
    logic clear;
    logic dbl;
    logic add;
    logic bit_in;
  } hrn_ctrl_t;

endpackage

[src/icg_in_if.sv]
// ----------------------------------------------------------------------------
// icg_in_if
// Request channel: opcode and seed with valid/ready handshake.
// ----------------------------------------------------------------------------
interface icg_in_if import icg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [ICG_SEED_W-1:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

[src/icg_out_if.sv]
// ----------------------------------------------------------------------------
// icg_out_if
// Result channel: generated value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface icg_out_if import icg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ICG_VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[src/inversive_congruential_prng.sv]
// ----------------------------------------------------------------------------
// inversive_congruential_prng
// Inversive congruential generator: x <- (a * inv(x) + c) mod m per request.
// ----------------------------------------------------------------------------
// One request is in flight at a time; a finished value waits in the output
// register while the next request is taken. The length of a next request
// grows with the number of Euclid division rounds for (m, x). The
// bit-serial divider and multiply-mod unit handle one quotient or
// multiplier bit at a time. A modulus below two returns 0. Registers
// multiplier, increment and modulus sit at APB byte offsets 0, 4, 8
// (8-byte stride when WIDTH exceeds 32) and should be written only while
// no request is outstanding.
`include "inversive_congruential_prng_defines.svh"

module inversive_congruential_prng import icg_pkg::*; #(
  parameter  int WIDTH  = ICG_WIDTH,
  localparam int CFG_DW = (WIDTH > 32) ? 64 : 32,
  localparam int CFG_LG = (WIDTH > 32) ? 3 : 2,
  localparam int CFG_AW = CFG_LG + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  icg_in_if.sink            in_if,
  icg_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [WIDTH-1:0]       mult_r;
  logic [WIDTH-1:0]       incr_r;
  logic [WIDTH-1:0]       mod_r;
  cfg_reg_t               cfg_idx;
  logic                   cfg_wr;

  logic                   eng_idle;
  logic                   eng_done;
  logic [WIDTH-1:0]       eng_value;
  logic                   start;
  logic                   out_free;
  logic                   out_valid_r, out_valid_nxt;
  logic [ICG_VALUE_W-1:0] value_r, value_nxt;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_AW-1:CFG_LG]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= WIDTH'(MULT_RESET);
      incr_r <= WIDTH'(INCR_RESET);
      mod_r  <= WIDTH'(MOD_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MULT: mult_r <= pwdata[WIDTH-1:0];
        REG_INCR: incr_r <= pwdata[WIDTH-1:0];
        REG_MOD:  mod_r  <= pwdata[WIDTH-1:0];
        default: begin
          mod_r <= mod_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MULT: prdata = CFG_DW'(mult_r);
      REG_INCR: prdata = CFG_DW'(incr_r);
      REG_MOD:  prdata = CFG_DW'(mod_r);
      default:  prdata = '0;
    endcase
  end

  // request side
  assign in_if.ready = eng_idle;
  assign start       = in_if.valid && eng_idle;
  assign out_free    = !out_valid_r || out_if.ready;

  icg_engine #(.WIDTH(WIDTH)) u_eng (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (start),
    .load_i     (in_if.opcode == OP_LOAD),
    .seed_i     (WIDTH'(in_if.seed_value)),
    .a_i        (mult_r),
    .c_i        (incr_r),
    .m_i        (mod_r),
    .out_free_i (out_free),
    .idle_o     (eng_idle),
    .done_o     (eng_done),
    .value_o    (eng_value)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    if (eng_done) begin
      out_valid_nxt = 1'b1;
      value_nxt     = ICG_VALUE_W'(eng_value);
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.value = value_r;

  `ICG_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)

endmodule

[src/icg_divser.sv]
// ----------------------------------------------------------------------------
// icg_divser
// Bit-serial restoring divider: one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
`include "inversive_congruential_prng_defines.svh"

module icg_divser import icg_pkg::*; #(
  parameter int WIDTH = ICG_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctrl_t        ctl_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] rem_o,
  output logic             qbit_o
);

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic             qbit_r, qbit_nxt;
  logic [WIDTH:0]   cand;
  logic [WIDTH:0]   diff;

  always_comb begin
    cand     = {rem_r, dvd_r[WIDTH-1]};
    diff     = cand - {1'b0, divisor_i};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    qbit_nxt = qbit_r;
    if (ctl_i.load) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend_i;
      qbit_nxt = 1'b0;
    end else if (ctl_i.step) begin
      qbit_nxt = (cand >= {1'b0, divisor_i});
      rem_nxt  = qbit_nxt ? diff[WIDTH-1:0] : cand[WIDTH-1:0];
      dvd_nxt  = {dvd_r[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    qbit_r <= qbit_nxt;
  end

  assign rem_o  = rem_r;
  assign qbit_o = qbit_r;

  // partial remainder stays below the divisor after every step
  `ICG_ASSERT_NEXT(a_rem_below_divisor, clk, rst_n, ctl_i.step, rem_r < divisor_i)

endmodule

[src/icg_horner.sv]
// ----------------------------------------------------------------------------
// icg_horner
// Serial multiply-mod: acc = 2*acc mod m, then acc += addend mod m per bit.
// ----------------------------------------------------------------------------
`include "inversive_congruential_prng_defines.svh"

module icg_horner import icg_pkg::*; #(
  parameter int WIDTH = ICG_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hrn_ctrl_t        ctl_i,
  input  logic [WIDTH-1:0] addend_i,
  input  logic [WIDTH-1:0] m_i,
  output logic [WIDTH-1:0] acc_o
);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] opnd;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   red;

  // one shared modular adder; both operands are below m
  always_comb begin
    opnd = ctl_i.dbl ? acc_r : addend_i;
    sum  = {1'b0, acc_r} + {1'b0, opnd};
    red  = (sum >= {1'b0, m_i}) ? (sum - {1'b0, m_i}) : sum;
    acc_nxt = acc_r;
    if (ctl_i.clear) begin
      acc_nxt = '0;
    end else if (ctl_i.dbl || (ctl_i.add && ctl_i.bit_in)) begin
      acc_nxt = red[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_o = acc_r;

  `ICG_ASSERT_IMPL(a_acc_reduced, clk, rst_n, ctl_i.dbl || ctl_i.add, acc_r < m_i)

endmodule

[src/icg_engine.sv]
// ----------------------------------------------------------------------------
// icg_engine
// Sequencer and state for one generator step: reductions, extended Euclid,
// multiply-mod and final add, all on the shared serial units.
// ----------------------------------------------------------------------------
`include "inversive_congruential_prng_defines.svh"

module icg_engine import icg_pkg::*; #(
  parameter int WIDTH = ICG_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic             load_i,
  input  logic [WIDTH-1:0] seed_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] c_i,
  input  logic [WIDTH-1:0] m_i,
  input  logic             out_free_i,
  output logic             idle_o,
  output logic             done_o,
  output logic [WIDTH-1:0] value_o
);

  localparam int CW = $clog2(WIDTH + 1);

  eng_state_t       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;
  logic [WIDTH-1:0] cur_r, cur_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] c_r, c_nxt;
  logic [WIDTH-1:0] rp_r, rp_nxt;
  logic [WIDTH-1:0] rc_r, rc_nxt;
  logic [WIDTH-1:0] sp_r, sp_nxt;
  logic [WIDTH-1:0] sc_r, sc_nxt;
  logic [WIDTH-1:0] inv_r, inv_nxt;

  div_ctrl_t        div_ctl;
  hrn_ctrl_t        hrn_ctl;
  logic [WIDTH-1:0] dividend;
  logic [WIDTH-1:0] divisor;
  logic [WIDTH-1:0] div_rem;
  logic             div_qbit;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] hrn_acc;

  logic             red_end;
  logic             ser_end;
  logic             m_small;
  logic [WIDTH:0]   sub_d;
  logic [WIDTH:0]   sub_res;
  logic [WIDTH:0]   fin_s;
  logic [WIDTH:0]   fin_res;

  icg_divser #(.WIDTH(WIDTH)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (div_ctl),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .rem_o      (div_rem),
    .qbit_o     (div_qbit)
  );

  icg_horner #(.WIDTH(WIDTH)) u_hrn (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (hrn_ctl),
    .addend_i (addend),
    .m_i      (m_i),
    .acc_o    (hrn_acc)
  );

  assign red_end = (cnt_r == CW'(WIDTH));
  assign ser_end = phase_r && (cnt_r == CW'(WIDTH - 1));
  assign m_small = (m_i < WIDTH'(2));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          if (m_small) state_nxt = ST_DONE;
          else if (load_i) state_nxt = ST_RED_SEED;
          else state_nxt = ST_RED_A;
        end
      end
      ST_RED_SEED: if (red_end) state_nxt = ST_DONE;
      ST_RED_A:    if (red_end) state_nxt = ST_RED_C;
      ST_RED_C:    if (red_end) state_nxt = ST_RED_X;
      ST_RED_X:    if (red_end) state_nxt = ST_EUC_CHK;
      ST_EUC_CHK:  state_nxt = (rc_r == '0) ? ST_MUL : ST_EUC_DIV;
      ST_EUC_DIV:  if (ser_end) state_nxt = ST_EUC_UPD;
      ST_EUC_UPD:  state_nxt = ST_EUC_CHK;
      ST_MUL:      if (ser_end) state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_DONE;
      ST_DONE:     if (out_free_i) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // unit controls and handshake outputs
  always_comb begin
    div_ctl  = '0;
    hrn_ctl  = '0;
    dividend = rp_r;
    divisor  = m_i;
    addend   = a_r;
    idle_o   = 1'b0;
    done_o   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle_o       = 1'b1;
        div_ctl.load = start_i;
        dividend     = load_i ? seed_i : a_i;
      end
      ST_RED_SEED, ST_RED_X: begin
        div_ctl.step = !red_end;
      end
      ST_RED_A: begin
        div_ctl.step = !red_end;
        div_ctl.load = red_end;
        dividend     = c_i;
      end
      ST_RED_C: begin
        div_ctl.step = !red_end;
        div_ctl.load = red_end;
        dividend     = cur_r;
      end
      ST_EUC_CHK: begin
        hrn_ctl.clear = 1'b1;
        div_ctl.load  = (rc_r != '0);
        dividend      = rp_r;
      end
      ST_EUC_DIV: begin
        divisor        = rc_r;
        div_ctl.step   = !phase_r;
        addend         = sc_r;
        hrn_ctl.dbl    = !phase_r;
        hrn_ctl.add    = phase_r;
        hrn_ctl.bit_in = div_qbit;
      end
      ST_MUL: begin
        addend         = a_r;
        hrn_ctl.dbl    = !phase_r;
        hrn_ctl.add    = phase_r;
        hrn_ctl.bit_in = inv_r[WIDTH-1];
      end
      ST_DONE: begin
        done_o = out_free_i;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  // s_prev - q*s_cur mod m, and prod + c mod m
  always_comb begin
    sub_d   = {1'b0, sp_r} - {1'b0, hrn_acc};
    sub_res = sub_d[WIDTH] ? (sub_d + {1'b0, m_i}) : sub_d;
    fin_s   = {1'b0, hrn_acc} + {1'b0, c_r};
    fin_res = (fin_s >= {1'b0, m_i}) ? (fin_s - {1'b0, m_i}) : fin_s;
  end

  // datapath and counters
  always_comb begin
    cur_nxt = cur_r;
    a_nxt   = a_r;
    c_nxt   = c_r;
    rp_nxt  = rp_r;
    rc_nxt  = rc_r;
    sp_nxt  = sp_r;
    sc_nxt  = sc_r;
    inv_nxt = inv_r;

    if (state_nxt != state_r) begin
      cnt_nxt   = '0;
      phase_nxt = 1'b0;
    end else if (state_r == ST_EUC_DIV || state_r == ST_MUL) begin
      cnt_nxt   = phase_r ? cnt_r + CW'(1) : cnt_r;
      phase_nxt = !phase_r;
    end else begin
      cnt_nxt   = cnt_r + CW'(1);
      phase_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (start_i && m_small) cur_nxt = '0;
      end
      ST_RED_SEED: if (red_end) cur_nxt = div_rem;
      ST_RED_A:    if (red_end) a_nxt = div_rem;
      ST_RED_C:    if (red_end) c_nxt = div_rem;
      ST_RED_X: begin
        if (red_end) begin
          rp_nxt = m_i;
          rc_nxt = div_rem;
          sp_nxt = '0;
          sc_nxt = WIDTH'(1);
        end
      end
      ST_EUC_CHK: begin
        if (rc_r == '0) inv_nxt = sp_r;
      end
      ST_EUC_UPD: begin
        rp_nxt = rc_r;
        rc_nxt = div_rem;
        sp_nxt = sc_r;
        sc_nxt = sub_res[WIDTH-1:0];
      end
      ST_MUL: begin
        if (phase_r) inv_nxt = {inv_r[WIDTH-2:0], 1'b0};
      end
      ST_FIN: cur_nxt = fin_res[WIDTH-1:0];
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    c_r   <= c_nxt;
    rp_r  <= rp_nxt;
    rc_r  <= rc_nxt;
    sp_r  <= sp_nxt;
    sc_r  <= sc_nxt;
    inv_r <= inv_nxt;
  end

  assign value_o = cur_r;

  `ICG_ASSERT_IMPL(a_divisor_nonzero, clk, rst_n, state_r == ST_EUC_DIV, rc_r != '0)
  `ICG_ASSERT_NEXT(a_coef_reduced, clk, rst_n, state_r == ST_EUC_UPD, sc_r < m_i)
  `ICG_ASSERT_NEXT(a_done_to_idle, clk, rst_n, done_o, state_r == ST_IDLE)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the inversive congruential PRNG. Predicts every
// value from its own copy of the registers and state, and runs directed
// corner cases, back-pressure and random phases under several register
// settings. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import icg_pkg::*;

  localparam int          IDLE_LIMIT = 20000;  // cycles with no handshake or register access at all
  localparam int          HOLD_OFF   = 4000;
  localparam int          TAIL       = 3500;
  localparam logic [1:0]  REG_SPARE  = 2'd3;   // unmapped register slot
  localparam logic [31:0] SMALL_PRIMES [6] = '{32'd3, 32'd5, 32'd7, 32'd251, 32'd65521,
                                              32'd65537};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  icg_in_if  in_ch ();
  icg_out_if out_ch ();

  inversive_congruential_prng DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // predicted registers and generator state
  logic [31:0] mult_r;
  logic [31:0] incr_r;
  logic [31:0] mod_r;
  logic [31:0] state_x;

  logic [31:0] pending_values [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          hold_cycles = 0;
  bit          steady = 1'b0;  // no random idling on either side while set

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  // Euclid coefficient of x modulo m, kept in [0, m); x = 0 gives 0
  function automatic longint unsigned euclid_inverse(longint unsigned x,
                                                     longint unsigned m);
    longint unsigned r_prev, r_cur, s_prev, s_cur, q, r_next, s_next, qs;
    r_prev = m;
    r_cur  = x;
    s_prev = 0;
    s_cur  = 1;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      qs     = ((q % m) * s_cur) % m;
      s_next = (s_prev >= qs) ? s_prev - qs : s_prev + (m - qs);
      r_prev = r_cur;
      r_cur  = r_next;
      s_prev = s_cur;
      s_cur  = s_next;
    end
    return s_prev;
  endfunction

  function automatic logic [31:0] icg_step(opcode_t op, logic [31:0] seed);
    longint unsigned m, x, inv, prod;
    m = mod_r;
    if (m < 2) begin
      state_x = '0;
    end else if (op == OP_LOAD) begin
      state_x = seed % m;
    end else begin
      x       = state_x % m;
      inv     = euclid_inverse(x, m);
      prod    = ((mult_r % m) * inv) % m;
      state_x = (prod + incr_r % m) % m;
    end
    return state_x;
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_MULT: return mult_r;
      REG_INCR: return incr_r;
      default:  return mod_r;
    endcase
  endfunction

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, optional long hold-off, and the check
  initial begin : result_sink
    int gap;
    logic [31:0] exp_value;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = draw_wait();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected value: expected none, actual %h", $time, out_ch.value);
        error_count++;
      end else begin
        exp_value = pending_values.pop_front();
        if (out_ch.value !== exp_value) begin
          $display("%0t: value mismatch: expected %h, actual %h", $time, exp_value,
                   out_ch.value);
          error_count++;
        end
      end
    end
  end

  // call at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input opcode_t op, input logic [31:0] seed);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.seed_value <= seed;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_values.push_back(icg_step(op, seed));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // write while idle, then read back mapped registers
  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_MULT: mult_r = data;
      REG_INCR: incr_r = data;
      REG_MOD:  mod_r  = data;
      default:  ;
    endcase
    if (idx == REG_SPARE) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end else begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (pready !== 1'b1) @(posedge clk);
      if (prdata !== reg_value(idx)) begin
        $display("%0t: register %0d readback: expected %h, actual %h", $time, idx,
                 reg_value(idx), prdata);
        error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk);
  endtask

  // reset defaults: a = 1, c = 1, m = 2^31 - 1, state 0
  task automatic test_reset_state();
    send_request(OP_NEXT, $urandom);  // inverse of zero is zero
    send_request(OP_NEXT, $urandom);
    send_request(OP_LOAD, 32'h0000_0000);
    send_request(OP_LOAD, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 32'h7FFF_FFFE);
    send_request(OP_NEXT, $urandom);
  endtask

  // all-ones registers (composite modulus, operands share factors), then zero multiplier and increment with modulus 2
  task automatic test_register_extremes();
    write_register(REG_MULT, 32'hFFFF_FFFF);
    write_register(REG_INCR, 32'hFFFF_FFFF);
    write_register(REG_MOD, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 32'hFFFF_FFFE);
    send_request(OP_NEXT, $urandom);
    send_request(OP_LOAD, 32'd255);       // gcd with m is 255, no inverse
    send_request(OP_NEXT, $urandom);
    send_request(OP_NEXT, $urandom);
    write_register(REG_MULT, 32'd0);
    write_register(REG_INCR, 32'd0);
    write_register(REG_MOD, 32'd2);
    send_request(OP_NEXT, $urandom);
    send_request(OP_LOAD, 32'd3);
    send_request(OP_NEXT, $urandom);
  endtask

  // state and registers left above a freshly lowered modulus
  task automatic test_modulus_rewrite();
    write_register(REG_MOD, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 32'hFFFF_FFF0);
    write_register(REG_MULT, 32'd12345678);
    write_register(REG_INCR, 32'd1000);
    write_register(REG_MOD, 32'd97);
    send_request(OP_NEXT, $urandom);
  endtask

  // modulus one and zero force the state to zero
  task automatic test_degenerate_modulus();
    write_register(REG_MOD, 32'd1);
    send_request(OP_LOAD, 32'd5);
    send_request(OP_NEXT, $urandom);
    write_register(REG_MOD, 32'd0);
    send_request(OP_LOAD, 32'hFFFF_FFFF);
    send_request(OP_NEXT, $urandom);
  endtask

  // writes past the last register change nothing
  task automatic test_unmapped_register();
    write_register(REG_MOD, 32'd65521);
    write_register(REG_SPARE, 32'hDEAD_BEEF);
    send_request(OP_LOAD, 32'd4242);
    send_request(OP_NEXT, $urandom);
  endtask

  // long result stall fills the block and stalls requests
  task automatic test_backpressure();
    wait_drained();
    steady      = 1'b1;
    hold_cycles = HOLD_OFF;
    repeat (10)
      send_request(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_NEXT, $urandom);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random_phases(input int total);
    int          sent, count, kind;
    logic [31:0] m;
    sent = 0;
    while (sent < total) begin
      steady = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: m = SMALL_PRIMES[$urandom_range(0, 5)];
        4, 5:       m = $urandom_range(4, 5000);
        6, 7:       m = $urandom;
        8: begin
          case ($urandom_range(0, 2))
            0:       m = 32'd2;
            1:       m = 32'hFFFF_FFFF;
            default: m = 32'h7FFF_FFFF;
          endcase
        end
        default:    m = $urandom_range(0, 1);
      endcase
      // the first write drains the previous phase
      write_register(REG_MOD, m);
      // mostly reduced operands, sometimes full-width ones
      if ($urandom_range(0, 3) != 0)
        write_register(REG_MULT, (m < 2) ? $urandom : $urandom % m);
      else
        write_register(REG_MULT, $urandom);
      if ($urandom_range(0, 3) != 0)
        write_register(REG_INCR, (m < 2) ? $urandom : $urandom % m);
      else
        write_register(REG_INCR, $urandom);
      // wide moduli mean long Euclid runs: keep those phases short
      count = (kind >= 6 && kind <= 8) ? $urandom_range(15, 30) : $urandom_range(30, 60);
      repeat (count)
        send_request(($urandom_range(0, 9) < 3) ? OP_LOAD : OP_NEXT, $urandom);
      sent += count;
    end
  endtask

  initial begin
    mult_r  = 32'd1;
    incr_r  = 32'd1;
    mod_r   = 32'd2147483647;
    state_x = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_NEXT;
    in_ch.seed_value <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_extremes();
    test_modulus_rewrite();
    test_degenerate_modulus();
    test_unmapped_register();
    test_backpressure();
    test_random_phases(680);

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (error_count == 0 && pending_values.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
